// ===== design/hfp_pkg.sv =====
// ----------------------------------------------------------------------------
// hfp_pkg
// Shared types, constants and Q1.31 arithmetic helpers for the HMM forward
// probability block.
// ----------------------------------------------------------------------------
package hfp_pkg;

  localparam logic [31:0] Q_ONE = 32'h8000_0000;

  typedef enum logic [1:0] {
    OP_OBSERVE    = 2'd0,
    OP_LOAD_TRANS = 2'd1,
    OP_LOAD_EMIT  = 2'd2,
    OP_LOAD_INIT  = 2'd3
  } op_t;

  // Control broadcast from the sequencer to every cell
  typedef struct packed {
    logic        load_trans;
    logic        load_emit;
    logic        load_init;
    logic [2:0]  row;
    logic [5:0]  col;
    logic [31:0] prob;
    logic        start;
    logic        first;
    logic [5:0]  symbol;
    logic        issue;
    logic        accum;
    logic        emit_mul;
    logic        shift;
  } cell_ctrl_t;

  // Q1.31 product, truncated
  function automatic logic [31:0] q_mul(input logic [31:0] a, input logic [31:0] b);
    logic [63:0] p;
    p = 64'(a) * 64'(b);
    return p[62:31];
  endfunction

  // Sum saturating at 1.0
  function automatic logic [31:0] q_add_sat(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s > {1'b0, Q_ONE}) ? Q_ONE : s[31:0];
  endfunction

endpackage

// ===== design/hfp_if.sv =====
// ----------------------------------------------------------------------------
// hfp_in_if / hfp_out_if
// Valid/ready channels for observation and load requests, and for the
// per-state results.
// ----------------------------------------------------------------------------
interface hfp_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [2:0]  row;
  logic [5:0]  col;
  logic [31:0] prob;
  logic [5:0]  symbol;
  logic        first;

  modport source (output valid, output op, output row, output col, output prob,
                  output symbol, output first, input ready);
  modport sink   (input valid, input op, input row, input col, input prob,
                  input symbol, input first, output ready);
endinterface

interface hfp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  state_index;
  logic [31:0] alpha;
  logic [31:0] likelihood;
  logic        last;

  modport source (output valid, output state_index, output alpha, output likelihood,
                  output last, input ready);
  modport sink   (input valid, input state_index, input alpha, input likelihood,
                  input last, output ready);
endinterface

// ===== design/hfp_ram.sv =====
// ----------------------------------------------------------------------------
// hfp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hfp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== design/hfp_cell.sv =====
// ----------------------------------------------------------------------------
// hfp_cell
// One hidden state: holds its transition column, initial and emission
// probabilities, its alpha in the rotating ring, and a multiply-accumulate.
// ----------------------------------------------------------------------------
module hfp_cell #(
  parameter int N_STATES    = 8,
  parameter int NUM_SYMBOLS = 64,
  parameter int CELL_IDX    = 0
) (
  input  logic               clk,
  input  logic               rst_n,
  input  hfp_pkg::cell_ctrl_t ctrl,
  input  logic [31:0]        alpha_in,
  output logic [31:0]        alpha_out
);
  import hfp_pkg::*;

  localparam int ST_W  = $clog2(N_STATES);
  localparam int SYM_W = $clog2(NUM_SYMBOLS);

  logic [31:0]     trans_r [N_STATES];
  logic [31:0]     init_r;
  logic [31:0]     alpha_r, alpha_nxt;
  logic [31:0]     acc_r;
  logic [31:0]     prod_r;
  logic [ST_W-1:0] idx_r;
  logic            sym_ok_r;
  logic [31:0]     emit_data;
  logic [31:0]     emit_eff;
  logic [31:0]     mul_a, mul_b, mul_q;
  logic            trans_we, emit_we, init_we;

  assign trans_we = ctrl.load_trans && (32'(ctrl.col) == CELL_IDX) &&
                    (32'(ctrl.row) < N_STATES);
  assign emit_we  = ctrl.load_emit && (32'(ctrl.row) == CELL_IDX) &&
                    (32'(ctrl.col) < NUM_SYMBOLS);
  assign init_we  = ctrl.load_init && (32'(ctrl.row) == CELL_IDX);

  hfp_ram #(
    .WIDTH (32),
    .DEPTH (NUM_SYMBOLS)
  ) u_emit_ram (
    .clk     (clk),
    .wr_en   (emit_we),
    .wr_addr (SYM_W'(ctrl.col)),
    .wr_data (ctrl.prob),
    .rd_en   (ctrl.start),
    .rd_addr (SYM_W'(ctrl.symbol)),
    .rd_data (emit_data)
  );

  assign emit_eff = sym_ok_r ? emit_data : '0;

  // shared multiplier: alpha x transition during accumulation, emission x sum at the end
  assign mul_a = ctrl.emit_mul ? emit_eff : alpha_r;
  assign mul_b = ctrl.emit_mul ? acc_r    : trans_r[idx_r];
  assign mul_q = q_mul(mul_a, mul_b);

  always_comb begin
    alpha_nxt = alpha_r;
    if (ctrl.emit_mul) begin
      alpha_nxt = mul_q;
    end else if (ctrl.shift) begin
      alpha_nxt = alpha_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r <= '0;
    end else begin
      alpha_r <= alpha_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (trans_we) begin
      trans_r[ST_W'(ctrl.row)] <= ctrl.prob;
    end
    if (init_we) begin
      init_r <= ctrl.prob;
    end
    if (ctrl.start) begin
      acc_r    <= ctrl.first ? init_r : '0;
      idx_r    <= ST_W'(CELL_IDX);
      sym_ok_r <= (32'(ctrl.symbol) < NUM_SYMBOLS);
    end else begin
      if (ctrl.accum) begin
        acc_r <= q_add_sat(acc_r, prod_r);
      end
      if (ctrl.issue) begin
        idx_r <= (32'(idx_r) == N_STATES - 1) ? '0 : idx_r + 1'b1;
      end
    end
    if (ctrl.issue) begin
      prod_r <= mul_q;
    end
  end

  assign alpha_out = alpha_r;

endmodule

// ===== design/hmm_forward_probability.sv =====
// ----------------------------------------------------------------------------
// hmm_forward_probability
// Forward pass of a hidden Markov model on a ring of per-state cells.
// ----------------------------------------------------------------------------
// Requests arrive on in_chan (valid/ready). Op load transition, emission or
// initial writes one table entry; loads give no result.
// Op observe runs one forward step: the alpha vector rotates around the ring
// of N_STATES cells, each cell multiplying the alpha passing by with its
// transition column and accumulating the products; a request with first set
// takes the initial probability instead. Each cell then multiplies its sum
// by the emission probability. The N_STATES results then leave on out_chan
// in state order, one per cycle while the receiver is ready, the last
// carrying the saturated sum of the alphas as likelihood.
// An observe request occupies the block from acceptance until its final
// result is registered, so the block takes no new request before then; the
// ring rotation and the output sequencing set this span.
// in_chan.ready is high only between observations. A stalled receiver holds
// the output register and pauses the ring; the block may accept the next
// request while the final result still waits.
// Reset clears the alpha vector and the sequencer; tables hold no reset
// value and must be loaded before use.
// ----------------------------------------------------------------------------
module hmm_forward_probability #(
  parameter int N_STATES    = 8,
  parameter int NUM_SYMBOLS = 64
) (
  input logic      clk,
  input logic      rst_n,
  hfp_in_if.sink   in_chan,
  hfp_out_if.source out_chan
);
  import hfp_pkg::*;

  localparam int CNT_W = $clog2(N_STATES + 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MAC  = 4'b0010,
    S_EMIT = 4'b0100,
    S_SEND = 4'b1000
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             first_r;
  logic [31:0]      total_r;
  logic             in_acc;
  logic             send_step;
  logic             issue;
  logic [31:0]      prob_sat;
  logic [31:0]      head;
  logic [31:0]      total_sum;
  logic             send_last;
  cell_ctrl_t       ctrl;
  logic [31:0]      alpha_bus [N_STATES];

  logic             out_valid_r;
  logic [2:0]       out_idx_r;
  logic [31:0]      out_alpha_r;
  logic [31:0]      out_lik_r;
  logic             out_last_r;

  assign in_chan.ready = (state_r == S_IDLE);
  assign in_acc        = in_chan.valid && in_chan.ready;
  assign prob_sat      = (in_chan.prob > Q_ONE) ? Q_ONE : in_chan.prob;
  assign issue         = (state_r == S_MAC) && (cnt_r < CNT_W'(N_STATES));
  assign send_step     = (state_r == S_SEND) && (!out_valid_r || out_chan.ready);
  assign send_last     = (cnt_r == CNT_W'(N_STATES - 1));
  assign head          = alpha_bus[0];
  assign total_sum     = q_add_sat(total_r, head);

  always_comb begin
    ctrl            = '0;
    ctrl.load_trans = in_acc && (in_chan.op == OP_LOAD_TRANS);
    ctrl.load_emit  = in_acc && (in_chan.op == OP_LOAD_EMIT);
    ctrl.load_init  = in_acc && (in_chan.op == OP_LOAD_INIT);
    ctrl.row        = in_chan.row;
    ctrl.col        = in_chan.col;
    ctrl.prob       = prob_sat;
    ctrl.start      = in_acc && (in_chan.op == OP_OBSERVE);
    ctrl.first      = in_chan.first;
    ctrl.symbol     = in_chan.symbol;
    ctrl.issue      = issue;
    ctrl.accum      = (state_r == S_MAC) && (cnt_r != '0) && !first_r;
    ctrl.emit_mul   = (state_r == S_EMIT);
    ctrl.shift      = issue || send_step;
  end

  genvar g;
  generate
    for (g = 0; g < N_STATES; g++) begin : g_cell
      hfp_cell #(
        .N_STATES    (N_STATES),
        .NUM_SYMBOLS (NUM_SYMBOLS),
        .CELL_IDX    (g)
      ) u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .alpha_in  (alpha_bus[(g + 1) % N_STATES]),
        .alpha_out (alpha_bus[g])
      );
    end
  endgenerate

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      S_IDLE: begin
        if (ctrl.start) begin
          state_nxt = S_MAC;
          cnt_nxt   = '0;
        end
      end
      S_MAC: begin
        if (cnt_r == CNT_W'(N_STATES)) begin
          state_nxt = S_EMIT;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_EMIT: begin
        state_nxt = S_SEND;
      end
      S_SEND: begin
        if (send_step) begin
          cnt_nxt = cnt_r + 1'b1;
          if (send_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (send_step) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      first_r <= in_chan.first;
    end
    if (state_r == S_EMIT) begin
      total_r <= '0;
    end else if (send_step) begin
      total_r <= total_sum;
    end
    if (send_step) begin
      out_idx_r   <= 3'(cnt_r);
      out_alpha_r <= head;
      out_lik_r   <= send_last ? total_sum : '0;
      out_last_r  <= send_last;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.state_index = out_idx_r;
  assign out_chan.alpha       = out_alpha_r;
  assign out_chan.likelihood  = out_lik_r;
  assign out_chan.last        = out_last_r;

endmodule
